/* design/nnsag_pkg.sv */
package nnsag_pkg;

    localparam int AddrW    = 32;
    localparam int CoordW   = 12;
    localparam int StepW    = 13;
    localparam int StrideW  = 13;
    localparam int DimW     = 12;
    localparam int IntW     = 12;
    localparam int FracW    = 10;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 32;

    localparam int ScaleOne      = 1000;
    localparam int MaxDimDefault = 4096;
    localparam int QueueDepth    = 2;

    localparam logic [CfgIdxW-1:0] CFG_SRC_STRIDE   = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_OUT_WIDTH    = 4'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEST_STRIDE  = 4'd2;
    localparam logic [CfgIdxW-1:0] CFG_OUT_HEIGHT   = 4'd3;
    localparam logic [CfgIdxW-1:0] CFG_W_RATIO_INT  = 4'd4;
    localparam logic [CfgIdxW-1:0] CFG_W_RATIO_FRAC = 4'd5;
    localparam logic [CfgIdxW-1:0] CFG_H_RATIO_INT  = 4'd6;
    localparam logic [CfgIdxW-1:0] CFG_H_RATIO_FRAC = 4'd7;

    typedef struct packed {
        logic [StrideW-1:0] src_stride;
        logic [DimW-1:0]    out_width;
        logic [StrideW-1:0] dest_stride;
        logic [DimW-1:0]    out_height;
        logic [IntW-1:0]    w_ratio_int;
        logic [FracW-1:0]   w_ratio_frac;
        logic [IntW-1:0]    h_ratio_int;
        logic [FracW-1:0]   h_ratio_frac;
    } cfg_t;

    typedef struct packed {
        logic [AddrW-1:0]  src_base;
        logic [AddrW-1:0]  dst_base;
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
        logic              row_end;
        logic              frame_end;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_STEP,
        BK_SUM,
        BK_MUL2,
        BK_ADD,
        BK_OUT
    } back_state_t;

endpackage

/* design/nearest_neighbor_scale_addr_gen.sv */
// Channel   Handshake                Payload
// in        in_valid / in_stall      src_base, dst_base
// out       out_valid / out_stall    src_addr, dst_addr, row_end, frame_end
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// In the back end each item leaves the queue, then passes the multiply, step update,
// sum, stride multiply, offset add and output load steps.
// The front end counts columns and rows and queues up to two items ahead.
// Reset clears the counters, queue and output valid, sets the steps to one and loads the config defaults.
// A stalled output holds the back end in its last step; the queue then fills and stalls the input.
module nearest_neighbor_scale_addr_gen
    import nnsag_pkg::*;
#(
    parameter int MAX_DIM = MaxDimDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [AddrW-1:0]    src_base,
    input  logic [AddrW-1:0]    dst_base,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [AddrW-1:0]    src_addr,
    output logic [AddrW-1:0]    dst_addr,
    output logic                row_end,
    output logic                frame_end,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          push;
    item_t         push_item;
    logic          pop;
    item_t         pop_item;
    queue_status_t queue_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_status.full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SRC_STRIDE:   cfg_next.src_stride   = cfg_data[StrideW-1:0];
                CFG_OUT_WIDTH:    cfg_next.out_width    = cfg_data[DimW-1:0];
                CFG_DEST_STRIDE:  cfg_next.dest_stride  = cfg_data[StrideW-1:0];
                CFG_OUT_HEIGHT:   cfg_next.out_height   = cfg_data[DimW-1:0];
                CFG_W_RATIO_INT:  cfg_next.w_ratio_int  = cfg_data[IntW-1:0];
                CFG_W_RATIO_FRAC: cfg_next.w_ratio_frac = cfg_data[FracW-1:0];
                CFG_H_RATIO_INT:  cfg_next.h_ratio_int  = cfg_data[IntW-1:0];
                CFG_H_RATIO_FRAC: cfg_next.h_ratio_frac = cfg_data[FracW-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_stride   <= '0;
            cfg_reg.out_width    <= DimW'(1);
            cfg_reg.dest_stride  <= '0;
            cfg_reg.out_height   <= DimW'(1);
            cfg_reg.w_ratio_int  <= IntW'(1);
            cfg_reg.w_ratio_frac <= '0;
            cfg_reg.h_ratio_int  <= IntW'(1);
            cfg_reg.h_ratio_frac <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nnsag_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .src_base   (src_base),
        .dst_base   (dst_base),
        .queue_full (queue_status.full),
        .push       (push),
        .push_item  (push_item)
    );

    nnsag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (queue_status)
    );

    nnsag_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_status (queue_status),
        .queue_item   (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

endmodule

/* design/nnsag_front.sv */
module nnsag_front
    import nnsag_pkg::*;
#(
    parameter int MAX_DIM = MaxDimDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  logic [AddrW-1:0] src_base,
    input  logic [AddrW-1:0] dst_base,
    input  logic             queue_full,
    output logic             push,
    output item_t            push_item
);

    localparam int CntW = ($clog2(MAX_DIM) > CoordW) ? CoordW : $clog2(MAX_DIM);
    localparam int DimBits = ($clog2(MAX_DIM + 1) > DimW) ? $clog2(MAX_DIM + 1) : DimW;
    localparam int CmpW = DimBits + 1;
    localparam logic [CmpW-1:0] MaxDimC = CmpW'(MAX_DIM);

    logic [CntW-1:0] col_reg;
    logic [CntW-1:0] col_next;
    logic [CntW-1:0] row_reg;
    logic [CntW-1:0] row_next;
    logic [CmpW-1:0] width_w;
    logic [CmpW-1:0] height_w;
    logic [CmpW-1:0] eff_width;
    logic [CmpW-1:0] eff_height;
    logic            row_end;
    logic            frame_end;

    assign push = in_valid && !queue_full;

    always_comb
    begin
        width_w    = CmpW'(cfg.out_width);
        height_w   = CmpW'(cfg.out_height);
        eff_width  = (width_w > MaxDimC) ? MaxDimC : width_w;
        eff_height = (height_w > MaxDimC) ? MaxDimC : height_w;
        row_end    = (CmpW'(col_reg) + CmpW'(1)) >= eff_width;
        frame_end  = row_end && ((CmpW'(row_reg) + CmpW'(1)) >= eff_height);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + CntW'(1);
            end
            else
            begin
                col_next = col_reg + CntW'(1);
            end
        end
    end

    always_comb
    begin
        push_item.src_base  = src_base;
        push_item.dst_base  = dst_base;
        push_item.col       = CoordW'(col_reg);
        push_item.row       = CoordW'(row_reg);
        push_item.row_end   = row_end;
        push_item.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* design/nnsag_queue.sv */
module nnsag_queue
    import nnsag_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         pop_item,
    output queue_status_t status
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    item_t           entry_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign status.full  = (count_reg == CntW'(QueueDepth));
    assign status.empty = (count_reg == '0);
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/nnsag_back.sv */
module nnsag_back
    import nnsag_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  queue_status_t    queue_status,
    input  item_t            queue_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [AddrW-1:0] src_addr,
    output logic [AddrW-1:0] dst_addr,
    output logic             row_end,
    output logic             frame_end
);

    localparam int ProdFW = FracW + CoordW;
    localparam int ProdIW = IntW + CoordW;
    localparam int CmpW   = StepW + FracW;
    localparam int SumW   = ProdIW + 1;
    localparam int MulW   = SumW + StrideW;
    localparam int DoffW  = CoordW + StrideW;
    localparam int OffW   = AddrW - 2;
    localparam logic [CmpW-1:0] ScaleC = CmpW'(ScaleOne);

    back_state_t         state_reg;
    back_state_t         state_next;
    item_t               item_reg;
    logic [StepW-1:0]    col_step_reg;
    logic [StepW-1:0]    col_step_next;
    logic [StepW-1:0]    row_step_reg;
    logic [StepW-1:0]    row_step_next;
    logic [ProdFW-1:0]   prod_h_reg;
    logic [ProdFW-1:0]   prod_w_reg;
    logic [ProdIW-1:0]   row_int_reg;
    logic [ProdIW-1:0]   col_int_reg;
    logic [SumW-1:0]     src_row_reg;
    logic [SumW-1:0]     src_col_reg;
    logic [MulW-1:0]     src_mul_reg;
    logic [DoffW-1:0]    dst_mul_reg;
    logic [OffW-1:0]     src_off_reg;
    logic [OffW-1:0]     dst_off_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [AddrW-1:0]    src_addr_reg;
    logic [AddrW-1:0]    dst_addr_reg;
    logic                row_end_reg;
    logic                frame_end_reg;
    logic                out_load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_status.empty)
                begin
                    state_next = BK_MUL1;
                end
            end
            BK_MUL1: state_next = BK_STEP;
            BK_STEP: state_next = BK_SUM;
            BK_SUM:  state_next = BK_MUL2;
            BK_MUL2: state_next = BK_ADD;
            BK_ADD:  state_next = BK_OUT;
            BK_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE: pop      = !queue_status.empty;
            BK_OUT:  out_load = !out_valid_reg || !out_stall;
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Steps advance before address math; row_end/frame_end reset col/row step to one.
    always_comb
    begin
        col_step_next = col_step_reg;
        row_step_next = row_step_reg;
        if (state_reg == BK_STEP)
        begin
            if ((item_reg.col == '0) &&
                (CmpW'(prod_h_reg) > CmpW'(row_step_reg) * ScaleC))
            begin
                row_step_next = row_step_reg + StepW'(1);
            end
            if (CmpW'(prod_w_reg) > CmpW'(col_step_reg) * ScaleC)
            begin
                col_step_next = col_step_reg + StepW'(1);
            end
        end
        else if (out_load)
        begin
            if (item_reg.row_end)
            begin
                col_step_next = StepW'(1);
            end
            if (item_reg.frame_end)
            begin
                row_step_next = StepW'(1);
            end
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= queue_item;
        end
        if (state_reg == BK_MUL1)
        begin
            prod_h_reg  <= ProdFW'(cfg.h_ratio_frac) * ProdFW'(item_reg.row);
            prod_w_reg  <= ProdFW'(cfg.w_ratio_frac) * ProdFW'(item_reg.col);
            row_int_reg <= ProdIW'(cfg.h_ratio_int) * ProdIW'(item_reg.row);
            col_int_reg <= ProdIW'(cfg.w_ratio_int) * ProdIW'(item_reg.col);
        end
        if (state_reg == BK_SUM)
        begin
            src_row_reg <= SumW'(row_int_reg) + SumW'(row_step_reg - StepW'(1));
            src_col_reg <= SumW'(col_int_reg) + SumW'(col_step_reg - StepW'(1));
        end
        if (state_reg == BK_MUL2)
        begin
            src_mul_reg <= MulW'(src_row_reg) * MulW'(cfg.src_stride);
            dst_mul_reg <= DoffW'(item_reg.row) * DoffW'(cfg.dest_stride);
        end
        if (state_reg == BK_ADD)
        begin
            src_off_reg <= OffW'(src_mul_reg) + OffW'(src_col_reg);
            dst_off_reg <= OffW'(dst_mul_reg) + OffW'(item_reg.col);
        end
        if (out_load)
        begin
            src_addr_reg  <= item_reg.src_base + {src_off_reg, 2'b00};
            dst_addr_reg  <= item_reg.dst_base + {dst_off_reg, 2'b00};
            row_end_reg   <= item_reg.row_end;
            frame_end_reg <= item_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            col_step_reg  <= StepW'(1);
            row_step_reg  <= StepW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_step_reg  <= col_step_next;
            row_step_reg  <= row_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign src_addr  = src_addr_reg;
    assign dst_addr  = dst_addr_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

/* design/nnsag_checker.sv */
module nnsag_checker
    import nnsag_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [AddrW-1:0]    src_base,
    input logic [AddrW-1:0]    dst_base,
    input logic                out_valid,
    input logic                out_stall,
    input logic [AddrW-1:0]    src_addr,
    input logic [AddrW-1:0]    dst_addr,
    input logic                row_end,
    input logic                frame_end
);

    // The last pixel of a frame is always the last pixel of its line.
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_end || !frame_end))
        else $error("frame_end without row_end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(src_addr) && $stable(dst_addr)
            && $stable(row_end) && $stable(frame_end))
        else $error("stalled output item changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(src_base) && $stable(dst_base))
        else $error("stalled input item changed");

    // No item can be finished in the cycle that follows reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind nearest_neighbor_scale_addr_gen nnsag_checker u_nnsag_checker (.*);
